/* rtl/core/g2xlp_pkg.sv */
// Shared types, constants and averaging helpers for the 2x grid prolongation block.
package g2xlp_pkg;

    localparam int MAX_COARSE_COLS = 512;
    localparam int MAX_COARSE_ROWS = 512;
    localparam int POS_W           = 10;
    localparam int COMP_W          = 32;
    localparam int ADDR_W          = $clog2(MAX_COARSE_COLS);
    localparam int CFG_IDX_W       = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFINE_ROWS = 2'd2;

    // kinds of fine point produced per coarse point, in emit order
    localparam logic [1:0] KIND_COPY = 2'd0;
    localparam logic [1:0] KIND_HMID = 2'd1;
    localparam logic [1:0] KIND_VMID = 2'd2;
    localparam logic [1:0] KIND_CTR  = 2'd3;

    typedef struct packed {
        logic signed [COMP_W-1:0] x_first;
        logic signed [COMP_W-1:0] y_first;
        logic signed [COMP_W-1:0] z_first;
        logic signed [COMP_W-1:0] x_second;
        logic signed [COMP_W-1:0] y_second;
        logic signed [COMP_W-1:0] z_second;
    } t_point;

    typedef struct packed {
        logic [POS_W-1:0]         fine_row;
        logic [POS_W-1:0]         fine_col;
        logic signed [COMP_W-1:0] out_x_first;
        logic signed [COMP_W-1:0] out_y_first;
        logic signed [COMP_W-1:0] out_z_first;
        logic signed [COMP_W-1:0] out_x_second;
        logic signed [COMP_W-1:0] out_y_second;
        logic signed [COMP_W-1:0] out_z_second;
        logic                     last_of_run;
        logic                     end_of_surface;
    } t_out_item;

    // floor((a+b)/2) on a sign-extended sum, never overflows
    function automatic logic signed [COMP_W-1:0] half_sum(
        input logic signed [COMP_W-1:0] a,
        input logic signed [COMP_W-1:0] b
    );
        logic signed [COMP_W:0] s;
        s = {a[COMP_W-1], a} + {b[COMP_W-1], b};
        return s[COMP_W:1];
    endfunction

    function automatic t_point avg_point(input t_point a, input t_point b);
        t_point r;
        r.x_first  = half_sum(a.x_first,  b.x_first);
        r.y_first  = half_sum(a.y_first,  b.y_first);
        r.z_first  = half_sum(a.z_first,  b.z_first);
        r.x_second = half_sum(a.x_second, b.x_second);
        r.y_second = half_sum(a.y_second, b.y_second);
        r.z_second = half_sum(a.z_second, b.z_second);
        return r;
    endfunction

endpackage

/* rtl/core/g2xlp_ifs.sv */
// Valid/ready channel interfaces for coarse points in and fine points out.
interface g2xlp_in_if;
    import g2xlp_pkg::*;
    logic   valid;
    logic   ready;
    t_point data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface g2xlp_out_if;
    import g2xlp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/grid_2x_linear_prolongation_unit.sv */
// Datapath: a coarse point transfer is held in the working stage, and its fine points
//   go out through the output register. Throughput: a coarse point yields one to four
//   fine points; the output channel moves one fine point per cycle unless stalled, and
//   the next point enters as the last fine point of the current one is registered out.
// Reset: positions return to row 1, column 1 and registers to their reset values;
//   the prior-row store and neighbor registers are not cleared.
module grid_2x_linear_prolongation_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [g2xlp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [g2xlp_pkg::POS_W-1:0]         i_cfg_data,
    g2xlp_in_if.sink                            i_pt,
    g2xlp_out_if.source                         o_fine
);
    import g2xlp_pkg::*;

    // configuration
    logic [POS_W-1:0] r_cols;
    logic [POS_W-1:0] r_rows;
    logic             r_refine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= POS_W'(1);
            r_rows   <= POS_W'(1);
            r_refine <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COARSE_COLS: r_cols   <= i_cfg_data;
                REG_COARSE_ROWS: r_rows   <= i_cfg_data;
                REG_REFINE_ROWS: r_refine <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [POS_W-1:0] cols_eff;
    logic [POS_W-1:0] rows_eff;

    always_comb begin
        if (r_cols == '0)                              cols_eff = POS_W'(1);
        else if (r_cols > POS_W'(MAX_COARSE_COLS))     cols_eff = POS_W'(MAX_COARSE_COLS);
        else                                           cols_eff = r_cols;
        if (r_rows == '0)                              rows_eff = POS_W'(1);
        else if (r_rows > POS_W'(MAX_COARSE_ROWS))     rows_eff = POS_W'(MAX_COARSE_ROWS);
        else                                           rows_eff = r_rows;
    end

    // handshake control
    logic       r_s1v;
    logic [1:0] r_kind;
    logic [1:0] n_kind;
    logic       kind_last;
    logic       r_ov;
    logic       out_free;
    logic       s1_adv;
    logic       s1_done;
    logic       in_fire;

    assign out_free    = !r_ov || o_fine.ready;
    assign s1_adv      = r_s1v && out_free;
    assign s1_done     = s1_adv && kind_last;
    assign i_pt.ready  = !r_s1v || s1_done;
    assign in_fire     = i_pt.valid && i_pt.ready;

    // raster position of the next coarse point
    logic [POS_W-1:0] r_rowp;
    logic [POS_W-1:0] r_colp;
    logic             row_end;
    logic             surf_end;

    assign row_end  = (r_colp >= cols_eff);
    assign surf_end = row_end && (r_rowp >= rows_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rowp <= POS_W'(1);
            r_colp <= POS_W'(1);
        end else if (in_fire) begin
            if (surf_end) begin
                r_rowp <= POS_W'(1);
                r_colp <= POS_W'(1);
            end else if (row_end) begin
                r_rowp <= r_rowp + POS_W'(1);
                r_colp <= POS_W'(1);
            end else begin
                r_colp <= r_colp + POS_W'(1);
            end
        end
    end

    // prior-row store: read old value and write current point in the same cycle
    t_point            mem [MAX_COARSE_COLS];
    t_point            r_above;
    logic [ADDR_W-1:0] slot;

    assign slot = ADDR_W'(r_colp - POS_W'(1));

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_above    <= mem[slot];
            mem[slot]  <= i_pt.data;
        end
    end

    // working stage: current point and its neighbors
    t_point           r_cur;
    t_point           r_left;
    t_point           r_ul;
    logic [POS_W-1:0] r_r;
    logic [POS_W-1:0] r_c;
    logic             r_ref_s;
    logic             r_has_h;
    logic             r_has_v;
    logic             r_surf;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_left  <= r_cur;
            r_ul    <= r_above;
            r_cur   <= i_pt.data;
            r_r     <= r_rowp;
            r_c     <= r_colp;
            r_ref_s <= r_refine;
            r_has_h <= (r_colp > POS_W'(1));
            r_has_v <= r_refine && (r_rowp > POS_W'(1));
            r_surf  <= surf_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v  <= 1'b0;
            r_kind <= KIND_COPY;
        end else if (in_fire) begin
            r_s1v  <= 1'b1;
            r_kind <= KIND_COPY;
        end else if (s1_done) begin
            r_s1v  <= 1'b0;
        end else if (s1_adv) begin
            r_kind <= n_kind;
        end
    end

    always_comb begin
        n_kind    = KIND_COPY;
        kind_last = 1'b1;
        unique case (r_kind)
            KIND_COPY: begin
                if (r_has_h) begin
                    n_kind = KIND_HMID; kind_last = 1'b0;
                end else if (r_has_v) begin
                    n_kind = KIND_VMID; kind_last = 1'b0;
                end
            end
            KIND_HMID: begin
                if (r_has_v) begin
                    n_kind = KIND_VMID; kind_last = 1'b0;
                end
            end
            KIND_VMID: begin
                if (r_has_h) begin
                    n_kind = KIND_CTR; kind_last = 1'b0;
                end
            end
            KIND_CTR: kind_last = 1'b1;
            default:  kind_last = 1'b1;
        endcase
    end

    // averages and fine indices
    t_point hmid;
    t_point vmid;
    t_point umid;
    t_point ctr;
    t_point sel;

    assign hmid = avg_point(r_left, r_cur);
    assign vmid = avg_point(r_above, r_cur);
    assign umid = avg_point(r_ul, r_above);
    assign ctr  = avg_point(umid, hmid);

    logic [POS_W:0]   r2;
    logic [POS_W:0]   c2;
    logic [POS_W-1:0] row_odd;
    logic [POS_W-1:0] row_even;
    logic [POS_W-1:0] col_odd;
    logic [POS_W-1:0] col_even;
    logic [POS_W-1:0] frow;
    logic [POS_W-1:0] fcol;

    assign r2       = {r_r, 1'b0};
    assign c2       = {r_c, 1'b0};
    assign row_odd  = r_ref_s ? POS_W'(r2 - (POS_W+1)'(1)) : r_r;
    assign row_even = POS_W'(r2 - (POS_W+1)'(2));
    assign col_odd  = POS_W'(c2 - (POS_W+1)'(1));
    assign col_even = POS_W'(c2 - (POS_W+1)'(2));

    always_comb begin
        case (r_kind)
            KIND_COPY: begin sel = r_cur; frow = row_odd;  fcol = col_odd;  end
            KIND_HMID: begin sel = hmid;  frow = row_odd;  fcol = col_even; end
            KIND_VMID: begin sel = vmid;  frow = row_even; fcol = col_odd;  end
            default:   begin sel = ctr;   frow = row_even; fcol = col_even; end
        endcase
    end

    // output register
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.fine_row       <= frow;
            r_out.fine_col       <= fcol;
            r_out.out_x_first    <= sel.x_first;
            r_out.out_y_first    <= sel.y_first;
            r_out.out_z_first    <= sel.z_first;
            r_out.out_x_second   <= sel.x_second;
            r_out.out_y_second   <= sel.y_second;
            r_out.out_z_second   <= sel.z_second;
            r_out.last_of_run    <= kind_last;
            r_out.end_of_surface <= kind_last && r_surf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_adv) begin
            r_ov <= 1'b1;
        end else if (o_fine.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_fine.valid = r_ov;
    assign o_fine.data  = r_out;

endmodule

/* rtl/core/g2xlp_checker.sv */
// Port-level checks for the 2x grid prolongation block, bound to its top level.
module g2xlp_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input g2xlp_pkg::t_out_item  i_out_data
);
    import g2xlp_pkg::*;

    // a stalled fine point holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("fine point changed while stalled");

    // surface end only on the final fine point of a coarse point
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.end_of_surface |-> i_out_data.last_of_run)
        else $error("end_of_surface without last_of_run");

    // every accepted coarse point must be followed by a valid fine point on the output
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("no fine point after coarse transfer");

    // fine indices are one-based
    a_idx_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.fine_row != '0) && (i_out_data.fine_col != '0))
        else $error("fine index zero");

    // output empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind grid_2x_linear_prolongation_unit g2xlp_checker u_g2xlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_fine.valid),
    .i_out_ready (o_fine.ready),
    .i_out_data  (o_fine.data)
);
